[src/stereo_ultrasonic_approach_step_assert.svh]
// assertion macros for the stereo ultrasonic approach step
`ifndef STEREO_ULTRASONIC_APPROACH_STEP_ASSERT_SVH
`define STEREO_ULTRASONIC_APPROACH_STEP_ASSERT_SVH

// same-cycle implication, off during reset
`define SUAS_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define SUAS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[src/suas_pkg.sv]
// shared types and constants for the stereo ultrasonic approach step
`timescale 1ns / 1ps

package suas_pkg;

   localparam int DIST_WIDTH_DEF = 16;
   localparam int PWM_W          = 10;
   localparam int CSR_AW         = 5;
   localparam int CSR_DW         = 32;

   localparam logic [PWM_W-1:0] PWM_MAX = 10'd1023;

   // register reset values
   localparam logic [15:0]      STOP_DISTANCE_RST = 16'd80;
   localparam logic [23:0]      STOP_HORIZON_RST  = 24'd300000;
   localparam logic [15:0]      CENTER_BAND_RST   = 16'd64;
   localparam logic [PWM_W-1:0] BASE_PWM_RST      = 10'd910;
   localparam logic [PWM_W-1:0] STEER_DELTA_RST   = 10'd70;

   // register index, byte address is 4x this
   typedef enum logic [2:0] {
      REG_STOP_DISTANCE = 3'd0,
      REG_STOP_HORIZON  = 3'd1,
      REG_CENTER_BAND   = 3'd2,
      REG_BASE_PWM      = 3'd3,
      REG_STEER_DELTA   = 3'd4
   } csr_reg_type;

   localparam logic [1:0] SECTOR_NONE   = 2'd0;
   localparam logic [1:0] SECTOR_LEFT   = 2'd1;
   localparam logic [1:0] SECTOR_RIGHT  = 2'd2;
   localparam logic [1:0] SECTOR_CENTER = 2'd3;

   // what one sensor lane reports
   typedef struct packed {
      logic             near;
      logic [PWM_W-1:0] pwm;
   } lane_out_type;

   // predictor side conditions
   typedef struct packed {
      logic closer;
      logic elapsed_nz;
   } pred_flags_type;

endpackage

[src/suas_lane.sv]
// one sensor side: nearer-side test and steered wheel pwm
`timescale 1ns / 1ps

module suas_lane import suas_pkg::*; #(
   parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
   input  logic                  own_valid,
   input  logic [DIST_WIDTH-1:0] own_dist,
   input  logic                  oth_valid,
   input  logic [DIST_WIDTH-1:0] oth_dist,
   input  logic [15:0]           center_band,
   input  logic [PWM_W-1:0]      base_pwm,
   input  logic [PWM_W-1:0]      steer_delta,
   output lane_out_type          lane_out
);

   localparam int CMP_W = (DIST_WIDTH > 16) ? DIST_WIDTH : 16;

   logic [DIST_WIDTH-1:0] diff;
   logic                  off_center;
   logic                  own_closer;
   logic                  far;
   logic [PWM_W:0]        up_sum;
   logic [PWM_W-1:0]      fast_pwm;
   logic [PWM_W-1:0]      slow_pwm;

   always_comb begin
      diff       = (own_dist > oth_dist) ? (own_dist - oth_dist) : (oth_dist - own_dist);
      off_center = CMP_W'(diff) > CMP_W'(center_band);
      own_closer = own_dist < oth_dist;
      lane_out.near = own_valid && (!oth_valid || (own_closer && off_center));
      far           = oth_valid && (!own_valid || (!own_closer && off_center));
      up_sum   = {1'b0, base_pwm} + {1'b0, steer_delta};
      fast_pwm = up_sum[PWM_W] ? PWM_MAX : up_sum[PWM_W-1:0];
      slow_pwm = (base_pwm < steer_delta) ? '0 : (base_pwm - steer_delta);
      if (lane_out.near) begin
         lane_out.pwm = slow_pwm;
      end else if (far) begin
         lane_out.pwm = fast_pwm;
      end else begin
         lane_out.pwm = base_pwm;
      end
   end

endmodule

[src/suas_pred.sv]
// approach predictor lane: cross products against one history choice, registered
`timescale 1ns / 1ps

module suas_pred import suas_pkg::*; #(
   parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic [DIST_WIDTH-1:0]  cur,
   input  logic [31:0]            now,
   input  logic [DIST_WIDTH-1:0]  prev_dist,
   input  logic [31:0]            prev_time,
   input  logic [15:0]            stop_distance,
   input  logic [23:0]            stop_horizon,
   output pred_flags_type         flags_ff,
   output logic [DIST_WIDTH+31:0] lhs_ff,
   output logic [DIST_WIDTH+23:0] rhs_ff
);

   localparam int LHS_W = DIST_WIDTH + 32;
   localparam int RHS_W = DIST_WIDTH + 24;

   logic [31:0]           elapsed;
   logic [DIST_WIDTH-1:0] margin;
   logic [DIST_WIDTH-1:0] closing;
   pred_flags_type        flags_in;
   logic [LHS_W-1:0]      lhs_in;
   logic [RHS_W-1:0]      rhs_in;

   // margin and closing only matter when they are positive
   always_comb begin
      elapsed = now - prev_time;
      margin  = cur - DIST_WIDTH'(stop_distance);
      closing = prev_dist - cur;
      lhs_in  = LHS_W'(margin) * LHS_W'(elapsed);
      rhs_in  = RHS_W'(closing) * RHS_W'(stop_horizon);
      flags_in.closer     = cur < prev_dist;
      flags_in.elapsed_nz = elapsed != '0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flags_ff <= flags_in;
         lhs_ff   <= lhs_in;
         rhs_ff   <= rhs_in;
      end
   end

endmodule

[src/stereo_ultrasonic_approach_step.sv]
// top level of the stereo ultrasonic approach step
`timescale 1ns / 1ps
// pipeline from item acceptance to result: lane/merge stage, product stage, output
// throughput: one item per cycle when not stalled, set by the stop decision on stage 2,
//   which reads history the item ahead may rewrite; both predictor lanes run every item
// reset: synchronous, clears pipeline valids and history, loads register defaults
// the input takes a new item while a result waits in the output register

module stereo_ultrasonic_approach_step import suas_pkg::*; #(
   parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // item input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_new_run,
   input  logic                  req_left_valid,
   input  logic [DIST_WIDTH-1:0] req_left_distance,
   input  logic                  req_right_valid,
   input  logic [DIST_WIDTH-1:0] req_right_distance,
   input  logic [31:0]           req_time_us,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_stop_reached,
   output logic                  rsp_distance_valid,
   output logic [1:0]            rsp_sector,
   output logic [DIST_WIDTH-1:0] rsp_closest_distance,
   output logic [PWM_W-1:0]      rsp_left_pwm,
   output logic [PWM_W-1:0]      rsp_right_pwm,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_AW-1:0]     csr_paddr,
   input  logic [CSR_DW-1:0]     csr_pwdata,
   output logic [CSR_DW-1:0]     csr_prdata,
   output logic                  csr_pready
);

   localparam int CMP_W = (DIST_WIDTH > 16) ? DIST_WIDTH : 16;
   localparam int LHS_W = DIST_WIDTH + 32;
   localparam int RHS_W = DIST_WIDTH + 24;

   // ---------------- configuration registers ----------------
   logic [15:0]      stop_distance_ff, stop_distance_in;
   logic [23:0]      stop_horizon_ff,  stop_horizon_in;
   logic [15:0]      center_band_ff,   center_band_in;
   logic [PWM_W-1:0] base_pwm_ff,      base_pwm_in;
   logic [PWM_W-1:0] steer_delta_ff,   steer_delta_in;
   logic             csr_write;
   csr_reg_type      csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_reg_type'(csr_paddr[4:2]);

   always_comb begin
      stop_distance_in = stop_distance_ff;
      stop_horizon_in  = stop_horizon_ff;
      center_band_in   = center_band_ff;
      base_pwm_in      = base_pwm_ff;
      steer_delta_in   = steer_delta_ff;
      csr_prdata       = '0;
      case (csr_index)
         REG_STOP_DISTANCE: begin
            if (csr_write) stop_distance_in = csr_pwdata[15:0];
            csr_prdata = CSR_DW'(stop_distance_ff);
         end
         REG_STOP_HORIZON: begin
            if (csr_write) stop_horizon_in = csr_pwdata[23:0];
            csr_prdata = CSR_DW'(stop_horizon_ff);
         end
         REG_CENTER_BAND: begin
            if (csr_write) center_band_in = csr_pwdata[15:0];
            csr_prdata = CSR_DW'(center_band_ff);
         end
         REG_BASE_PWM: begin
            if (csr_write) base_pwm_in = csr_pwdata[PWM_W-1:0];
            csr_prdata = CSR_DW'(base_pwm_ff);
         end
         REG_STEER_DELTA: begin
            if (csr_write) steer_delta_in = csr_pwdata[PWM_W-1:0];
            csr_prdata = CSR_DW'(steer_delta_ff);
         end
         default: begin
            // unmapped index, writes dropped, reads zero
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_distance_ff <= STOP_DISTANCE_RST;
         stop_horizon_ff  <= STOP_HORIZON_RST;
         center_band_ff   <= CENTER_BAND_RST;
         base_pwm_ff      <= BASE_PWM_RST;
         steer_delta_ff   <= STEER_DELTA_RST;
      end else begin
         stop_distance_ff <= stop_distance_in;
         stop_horizon_ff  <= stop_horizon_in;
         center_band_ff   <= center_band_in;
         base_pwm_ff      <= base_pwm_in;
         steer_delta_ff   <= steer_delta_in;
      end
   end

   // ---------------- pipeline flow control ----------------
   // each stage moves when the one after it is empty or moving too
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_en, s2_move, s2_free, s1_move, s1_free, req_take;

   assign out_en   = !rsp_valid_ff || !rsp_stall;
   assign s2_move  = s2_valid_ff && out_en;
   assign s2_free  = !s2_valid_ff || out_en;
   assign s1_move  = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign req_take = req_valid && s1_free;
   assign req_stall = !s1_free;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s2_free);
   assign s2_valid_in  = s1_move || (s2_valid_ff && !out_en);
   assign rsp_valid_in = out_en ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- sensor lanes and merge ----------------
   lane_out_type          left_lane;
   lane_out_type          right_lane;
   logic                  any_in;
   logic [1:0]            sector_in;
   logic [DIST_WIDTH-1:0] cur_in;

   suas_lane #(.DIST_WIDTH(DIST_WIDTH)) u_lane_left (
      .own_valid   (req_left_valid),
      .own_dist    (req_left_distance),
      .oth_valid   (req_right_valid),
      .oth_dist    (req_right_distance),
      .center_band (center_band_ff),
      .base_pwm    (base_pwm_ff),
      .steer_delta (steer_delta_ff),
      .lane_out    (left_lane)
   );

   suas_lane #(.DIST_WIDTH(DIST_WIDTH)) u_lane_right (
      .own_valid   (req_right_valid),
      .own_dist    (req_right_distance),
      .oth_valid   (req_left_valid),
      .oth_dist    (req_left_distance),
      .center_band (center_band_ff),
      .base_pwm    (base_pwm_ff),
      .steer_delta (steer_delta_ff),
      .lane_out    (right_lane)
   );

   // merge: the nearer lane names the sector, both valid and neither nearer is center
   always_comb begin
      any_in = req_left_valid || req_right_valid;
      if (!any_in) begin
         sector_in = SECTOR_NONE;
      end else if (left_lane.near) begin
         sector_in = SECTOR_LEFT;
      end else if (right_lane.near) begin
         sector_in = SECTOR_RIGHT;
      end else begin
         sector_in = SECTOR_CENTER;
      end
      if (req_left_valid && req_right_valid) begin
         cur_in = (req_left_distance < req_right_distance) ? req_left_distance
                                                           : req_right_distance;
      end else if (req_left_valid) begin
         cur_in = req_left_distance;
      end else if (req_right_valid) begin
         cur_in = req_right_distance;
      end else begin
         cur_in = '0;
      end
   end

   // stage 1 payload
   logic                  s1_new_run_ff;
   logic                  s1_any_ff;
   logic [1:0]            s1_sector_ff;
   logic [DIST_WIDTH-1:0] s1_cur_ff;
   logic [31:0]           s1_time_ff;
   logic [PWM_W-1:0]      s1_lpwm_ff;
   logic [PWM_W-1:0]      s1_rpwm_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_new_run_ff <= req_new_run;
         s1_any_ff     <= any_in;
         s1_sector_ff  <= sector_in;
         s1_cur_ff     <= cur_in;
         s1_time_ff    <= req_time_us;
         s1_lpwm_ff    <= left_lane.pwm;
         s1_rpwm_ff    <= right_lane.pwm;
      end
   end

   // ---------------- history ----------------
   logic                  have_prev_ff, have_prev_in;
   logic [DIST_WIDTH-1:0] prev_dist_ff, prev_dist_in;
   logic [31:0]           prev_time_ff, prev_time_in;

   // stage 2 payload
   logic                  s2_new_run_ff;
   logic                  s2_any_ff;
   logic [1:0]            s2_sector_ff;
   logic [DIST_WIDTH-1:0] s2_cur_ff;
   logic [31:0]           s2_time_ff;
   logic [PWM_W-1:0]      s2_lpwm_ff;
   logic [PWM_W-1:0]      s2_rpwm_ff;
   logic                  s2_sel_fwd_ff, s2_sel_fwd_in;

   // ---------------- predictor lanes ----------------
   // lane a measures against stored history, lane b against the item in stage 2,
   // which is what history becomes if that item moves on with a reading and without a stop
   pred_flags_type   flags_a, flags_b, flags_sel;
   logic [LHS_W-1:0] lhs_a, lhs_b, lhs_sel;
   logic [RHS_W-1:0] rhs_a, rhs_b, rhs_sel;

   suas_pred #(.DIST_WIDTH(DIST_WIDTH)) u_pred_hist (
      .clock         (clock),
      .load          (s1_move),
      .cur           (s1_cur_ff),
      .now           (s1_time_ff),
      .prev_dist     (prev_dist_ff),
      .prev_time     (prev_time_ff),
      .stop_distance (stop_distance_ff),
      .stop_horizon  (stop_horizon_ff),
      .flags_ff      (flags_a),
      .lhs_ff        (lhs_a),
      .rhs_ff        (rhs_a)
   );

   suas_pred #(.DIST_WIDTH(DIST_WIDTH)) u_pred_fwd (
      .clock         (clock),
      .load          (s1_move),
      .cur           (s1_cur_ff),
      .now           (s1_time_ff),
      .prev_dist     (s2_cur_ff),
      .prev_time     (s2_time_ff),
      .stop_distance (stop_distance_ff),
      .stop_horizon  (stop_horizon_ff),
      .flags_ff      (flags_b),
      .lhs_ff        (lhs_b),
      .rhs_ff        (rhs_b)
   );

   // ---------------- stop decision on stage 2 ----------------
   logic s2_near, s2_have_prev, s2_predicted, s2_stop, s2_update;

   always_comb begin
      flags_sel    = s2_sel_fwd_ff ? flags_b : flags_a;
      lhs_sel      = s2_sel_fwd_ff ? lhs_b : lhs_a;
      rhs_sel      = s2_sel_fwd_ff ? rhs_b : rhs_a;
      // a new run wipes history before this item looks at it
      s2_have_prev = !s2_new_run_ff && (s2_sel_fwd_ff || have_prev_ff);
      s2_near      = CMP_W'(s2_cur_ff) <= CMP_W'(stop_distance_ff);
      s2_predicted = s2_have_prev && flags_sel.closer && flags_sel.elapsed_nz
                     && (lhs_sel <= LHS_W'(rhs_sel));
      s2_stop      = s2_any_ff && (s2_near || s2_predicted);
      s2_update    = s2_any_ff && !s2_stop;
   end

   // stage 1 item uses lane b when the stage 2 item updates history on the same edge
   assign s2_sel_fwd_in = s2_valid_ff && s2_update;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_new_run_ff <= s1_new_run_ff;
         s2_any_ff     <= s1_any_ff;
         s2_sector_ff  <= s1_sector_ff;
         s2_cur_ff     <= s1_cur_ff;
         s2_time_ff    <= s1_time_ff;
         s2_lpwm_ff    <= s1_lpwm_ff;
         s2_rpwm_ff    <= s1_rpwm_ff;
         s2_sel_fwd_ff <= s2_sel_fwd_in;
      end
   end

   // history commits when the stage 2 item moves to the output
   always_comb begin
      have_prev_in = have_prev_ff;
      prev_dist_in = prev_dist_ff;
      prev_time_in = prev_time_ff;
      if (s2_move) begin
         if (s2_update) begin
            have_prev_in = 1'b1;
            prev_dist_in = s2_cur_ff;
            prev_time_in = s2_time_ff;
         end else if (s2_new_run_ff) begin
            have_prev_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         prev_dist_ff <= '0;
         prev_time_ff <= '0;
      end else begin
         have_prev_ff <= have_prev_in;
         prev_dist_ff <= prev_dist_in;
         prev_time_ff <= prev_time_in;
      end
   end

   // ---------------- output register ----------------
   logic                  rsp_stop_ff;
   logic                  rsp_any_ff;
   logic [1:0]            rsp_sector_ff;
   logic [DIST_WIDTH-1:0] rsp_cur_ff;
   logic [PWM_W-1:0]      rsp_lpwm_ff, rsp_lpwm_in;
   logic [PWM_W-1:0]      rsp_rpwm_ff, rsp_rpwm_in;

   // wheels are held on stop
   assign rsp_lpwm_in = s2_stop ? '0 : s2_lpwm_ff;
   assign rsp_rpwm_in = s2_stop ? '0 : s2_rpwm_ff;

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_stop_ff   <= s2_stop;
         rsp_any_ff    <= s2_any_ff;
         rsp_sector_ff <= s2_sector_ff;
         rsp_cur_ff    <= s2_cur_ff;
         rsp_lpwm_ff   <= rsp_lpwm_in;
         rsp_rpwm_ff   <= rsp_rpwm_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_stop_reached     = rsp_stop_ff;
   assign rsp_distance_valid   = rsp_any_ff;
   assign rsp_sector           = rsp_sector_ff;
   assign rsp_closest_distance = rsp_cur_ff;
   assign rsp_left_pwm         = rsp_lpwm_ff;
   assign rsp_right_pwm        = rsp_rpwm_ff;

endmodule

[src/suas_checker.sv]
// port-level checks on the approach step results, bound to the top level
`timescale 1ns / 1ps
`include "stereo_ultrasonic_approach_step_assert.svh"

module suas_checker import suas_pkg::*; #(
   parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_stop_reached,
   input logic                  rsp_distance_valid,
   input logic [1:0]            rsp_sector,
   input logic [DIST_WIDTH-1:0] rsp_closest_distance,
   input logic [PWM_W-1:0]      rsp_left_pwm,
   input logic [PWM_W-1:0]      rsp_right_pwm
);

   logic                          wheels_off;
   logic                          none_quiet;
   logic                          sector_named;
   logic                          rsp_hold;
   logic [DIST_WIDTH+2*PWM_W+3:0] rsp_bundle;

   assign wheels_off   = (rsp_left_pwm == '0) && (rsp_right_pwm == '0);
   assign none_quiet   = (rsp_sector == SECTOR_NONE) && (rsp_closest_distance == '0)
                         && !rsp_stop_reached;
   assign sector_named = rsp_sector != SECTOR_NONE;
   assign rsp_hold     = rsp_valid && rsp_stall;
   assign rsp_bundle   = {rsp_stop_reached, rsp_distance_valid, rsp_sector,
                          rsp_closest_distance, rsp_left_pwm, rsp_right_pwm};

   // a stop result drives both wheels to zero
   `SUAS_ASSERT_NOW(a_stop_zero_pwm, clock, reset, rsp_valid && rsp_stop_reached, wheels_off)

   // with no reading there is no sector, no distance and no stop
   `SUAS_ASSERT_NOW(a_none_quiet, clock, reset, rsp_valid && !rsp_distance_valid, none_quiet)

   // a valid reading always names a sector
   `SUAS_ASSERT_NOW(a_valid_sector, clock, reset, rsp_valid && rsp_distance_valid, sector_named)

   // a stalled result holds
   `SUAS_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_hold, rsp_valid && $stable(rsp_bundle))

endmodule

bind stereo_ultrasonic_approach_step suas_checker #(.DIST_WIDTH(DIST_WIDTH)) u_suas_checker (.*);

[tb/tb_top.sv]
// self-checking testbench for the stereo ultrasonic approach step
`timescale 1ns / 1ps

module tb_top import suas_pkg::*; ();

   localparam int DW = DIST_WIDTH_DEF;
   // longest correct quiet stretch is a sender gap plus a receiver stall plus the pipe
   localparam int WATCHDOG_LIMIT = 2000;
   // register index past the end of the map, writes there must be dropped
   localparam logic [2:0] REG_UNMAPPED = 3'd7;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 100;

   // one stereo reading as it crosses the input channel
   typedef struct packed {
      logic          new_run;
      logic          lv;
      logic [DW-1:0] ld;
      logic          rv;
      logic [DW-1:0] rd;
      logic [31:0]   t;
   } reading_type;

   // one approach decision as it crosses the result channel
   typedef struct packed {
      logic             stop;
      logic             dist_valid;
      logic [1:0]       sector;
      logic [DW-1:0]    closest;
      logic [PWM_W-1:0] left_pwm;
      logic [PWM_W-1:0] right_pwm;
   } decision_type;

   typedef struct {
      reading_type  rd;
      bit           typed;
      decision_type want;
   } table_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_new_run = 1'b0;
   logic              req_left_valid = 1'b0;
   logic [DW-1:0]     req_left_distance = '0;
   logic              req_right_valid = 1'b0;
   logic [DW-1:0]     req_right_distance = '0;
   logic [31:0]       req_time_us = '0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_stop_reached;
   logic              rsp_distance_valid;
   logic [1:0]        rsp_sector;
   logic [DW-1:0]     rsp_closest_distance;
   logic [PWM_W-1:0]  rsp_left_pwm;
   logic [PWM_W-1:0]  rsp_right_pwm;

   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // register shadow, starts at the reset values
   logic [15:0]       cfg_stop_dist = STOP_DISTANCE_RST;
   logic [23:0]       cfg_horizon = STOP_HORIZON_RST;
   logic [15:0]       cfg_band = CENTER_BAND_RST;
   logic [PWM_W-1:0]  cfg_base = BASE_PWM_RST;
   logic [PWM_W-1:0]  cfg_steer = STEER_DELTA_RST;

   // last remembered reading, as the block keeps it
   bit                hist_valid = 1'b0;
   logic [DW-1:0]     hist_dist = '0;
   logic [31:0]       hist_time = '0;

   // approach sequence generator state
   int                gen_dist = 0;
   logic [31:0]       gen_time = '0;

   decision_type      pending_decisions[$];
   table_row_type     directed_rows[$];
   int                mismatches = 0;
   int                quiet_cycles = 0;
   int                stall_left = 0;
   bit                send_quiet = 1'b0;
   bit                recv_quiet = 1'b0;

   stereo_ultrasonic_approach_step #(
      .DIST_WIDTH(DW)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_new_run         (req_new_run),
      .req_left_valid      (req_left_valid),
      .req_left_distance   (req_left_distance),
      .req_right_valid     (req_right_valid),
      .req_right_distance  (req_right_distance),
      .req_time_us         (req_time_us),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_stop_reached    (rsp_stop_reached),
      .rsp_distance_valid  (rsp_distance_valid),
      .rsp_sector          (rsp_sector),
      .rsp_closest_distance(rsp_closest_distance),
      .rsp_left_pwm        (rsp_left_pwm),
      .rsp_right_pwm       (rsp_right_pwm),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [PWM_W-1:0] pwm_limit(input int v);
      if (v < 0) return '0;
      if (v > int'(PWM_MAX)) return PWM_MAX;
      return v[PWM_W-1:0];
   endfunction

   // expected decision for one reading, advances the remembered reading
   function automatic decision_type approach_decision(input reading_type r);
      decision_type  d;
      logic [DW-1:0] cur;
      logic [DW-1:0] diff;
      logic [31:0]   elapsed;
      logic [63:0]   lhs;
      logic [63:0]   rhs;
      int            lp;
      int            rp;
      int            steer;
      bit            halt;
      d = '0;
      d.sector = SECTOR_NONE;
      cur = '0;
      halt = 1'b0;
      lp = int'(cfg_base);
      rp = lp;
      steer = int'(cfg_steer);
      if (r.new_run) hist_valid = 1'b0;
      if (r.lv && r.rv) begin
         diff = (r.ld > r.rd) ? r.ld - r.rd : r.rd - r.ld;
         cur = (r.ld < r.rd) ? r.ld : r.rd;
         if (diff <= cfg_band) begin
            d.sector = SECTOR_CENTER;
         end else if (r.ld < r.rd) begin
            d.sector = SECTOR_LEFT;
            lp -= steer;
            rp += steer;
         end else begin
            d.sector = SECTOR_RIGHT;
            lp += steer;
            rp -= steer;
         end
      end else if (r.lv) begin
         d.sector = SECTOR_LEFT;
         cur = r.ld;
         lp -= steer;
         rp += steer;
      end else if (r.rv) begin
         d.sector = SECTOR_RIGHT;
         cur = r.rd;
         lp += steer;
         rp -= steer;
      end
      if (r.lv || r.rv) begin
         if (cur <= cfg_stop_dist) begin
            halt = 1'b1;
         end else if (hist_valid && cur < hist_dist) begin
            // closing speed extrapolated over the horizon, compared cross-multiplied
            elapsed = r.t - hist_time;
            if (elapsed != 0) begin
               lhs = (64'(cur) - 64'(cfg_stop_dist)) * 64'(elapsed);
               rhs = (64'(hist_dist) - 64'(cur)) * 64'(cfg_horizon);
               halt = (lhs <= rhs);
            end
         end
         if (!halt) begin
            hist_dist = cur;
            hist_time = r.t;
            hist_valid = 1'b1;
         end
      end
      d.stop = halt;
      d.dist_valid = r.lv || r.rv;
      d.closest = cur;
      d.left_pwm = halt ? '0 : pwm_limit(lp);
      d.right_pwm = halt ? '0 : pwm_limit(rp);
      return d;
   endfunction

   function automatic void add_row(input bit nr, lv, input int ld, input bit rv,
                                   input int rd, input logic [31:0] t, input bit typed,
                                   input bit stop, dv, input logic [1:0] sec,
                                   input int close, lp, rp);
      table_row_type row;
      row.rd = '{new_run: nr, lv: lv, ld: ld[DW-1:0], rv: rv, rd: rd[DW-1:0], t: t};
      row.typed = typed;
      row.want = '{stop: stop, dist_valid: dv, sector: sec, closest: close[DW-1:0],
                   left_pwm: lp[PWM_W-1:0], right_pwm: rp[PWM_W-1:0]};
      directed_rows.push_back(row);
   endfunction

   // mostly approach runs with random content, the rest pure noise
   function automatic reading_type next_reading();
      reading_type r;
      int          step;
      int          near_d;
      int          far_d;
      logic [31:0] dt;
      logic [63:0] rhs;
      logic [63:0] bound;
      if ($urandom_range(0, 99) < 18) begin
         r.new_run = 1'($urandom_range(0, 1));
         r.lv = 1'($urandom_range(0, 1));
         r.ld = DW'($urandom);
         r.rv = 1'($urandom_range(0, 1));
         r.rd = DW'($urandom);
         r.t = $urandom;
         return r;
      end
      r.new_run = 1'b0;
      if ((gen_dist <= int'(cfg_stop_dist) && $urandom_range(0, 2) == 0) ||
          $urandom_range(0, 24) == 0) begin
         // fresh run from somewhere out in front, any time base
         r.new_run = 1'b1;
         gen_dist = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(int'(cfg_stop_dist), 65535);
         gen_time = $urandom;
      end else begin
         step = ($urandom_range(0, 9) == 0) ? -int'($urandom_range(1, 300))
                                            : int'($urandom_range(0, 600));
         gen_dist -= step;
         if (gen_dist < 0) gen_dist = 0;
         if (gen_dist > 65535) gen_dist = 65535;
         dt = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 80000));
         if (hist_valid && gen_dist < int'(hist_dist) && gen_dist > int'(cfg_stop_dist) &&
             $urandom_range(0, 2) == 0) begin
            // land on or right beside the predicted stop boundary
            rhs = (64'(hist_dist) - 64'(gen_dist)) * 64'(cfg_horizon);
            bound = rhs / (64'(gen_dist) - 64'(cfg_stop_dist));
            bound = bound + $urandom_range(0, 2) - 1;
            if (bound < 64'h1_0000_0000) gen_time = hist_time + bound[31:0];
            else gen_time = gen_time + dt;
         end else begin
            gen_time = gen_time + dt;
         end
      end
      near_d = gen_dist;
      r.ld = DW'($urandom);
      r.rd = DW'($urandom);
      r.lv = 1'b1;
      r.rv = 1'b1;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            far_d = near_d + int'($urandom_range(0, int'(cfg_band)));
            if (far_d > 65535) far_d = 65535;
            if ($urandom_range(0, 1)) begin
               r.ld = DW'(near_d);
               r.rd = DW'(far_d);
            end else begin
               r.ld = DW'(far_d);
               r.rd = DW'(near_d);
            end
         end
         4, 5, 6, 7: begin
            far_d = near_d + int'(cfg_band) + 1 + int'($urandom_range(0, 2000));
            if (far_d > 65535) far_d = 65535;
            if ($urandom_range(0, 1)) begin
               r.ld = DW'(near_d);
               r.rd = DW'(far_d);
            end else begin
               r.ld = DW'(far_d);
               r.rd = DW'(near_d);
            end
         end
         8: begin
            r.ld = DW'(near_d);
            r.rv = 1'b0;
         end
         default: begin
            r.rd = DW'(near_d);
            r.lv = 1'b0;
         end
      endcase
      r.t = gen_time;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function automatic logic [31:0] shadow_value(input csr_reg_type idx);
      case (idx)
         REG_STOP_DISTANCE: return 32'(cfg_stop_dist);
         REG_STOP_HORIZON:  return 32'(cfg_horizon);
         REG_CENTER_BAND:   return 32'(cfg_band);
         REG_BASE_PWM:      return 32'(cfg_base);
         REG_STEER_DELTA:   return 32'(cfg_steer);
         default:           return '0;
      endcase
   endfunction

   // setup then access, the write lands on the access edge with pready high
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_STOP_DISTANCE: cfg_stop_dist = value[15:0];
         REG_STOP_HORIZON:  cfg_horizon = value[23:0];
         REG_CENTER_BAND:   cfg_band = value[15:0];
         REG_BASE_PWM:      cfg_base = value[PWM_W-1:0];
         REG_STEER_DELTA:   cfg_steer = value[PWM_W-1:0];
         default: ;
      endcase
      // return to idle before the next transfer
      @(posedge clock);
   endtask

   task automatic csr_readback(input csr_reg_type idx);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field(idx.name(), shadow_value(idx), csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      // return to idle before the next transfer
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [31:0] sd, h, band, base, steer);
      csr_write(REG_STOP_DISTANCE, sd);
      csr_write(REG_STOP_HORIZON, h);
      csr_write(REG_CENTER_BAND, band);
      csr_write(REG_BASE_PWM, base);
      csr_write(REG_STEER_DELTA, steer);
      // junk to an unmapped slot, the readback shows nothing moved
      csr_write(REG_UNMAPPED, $urandom);
      for (int i = 0; i <= int'(REG_STEER_DELTA); i++) csr_readback(csr_reg_type'(i));
   endtask

   // offer one reading after a random gap, expectation queued on acceptance
   task automatic offer_reading(input reading_type r, input bit typed,
                                input decision_type want);
      int           gap;
      decision_type d;
      gap = send_quiet ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_new_run <= r.new_run;
      req_left_valid <= r.lv;
      req_left_distance <= r.ld;
      req_right_valid <= r.rv;
      req_right_distance <= r.rd;
      req_time_us <= r.t;
      do @(posedge clock); while (req_stall);
      d = approach_decision(r);
      pending_decisions.push_back(typed ? want : d);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_decisions.size() != 0) @(posedge clock);
   endtask

   // result side: compare each accepted item, then draw the stall before the next one
   always @(posedge clock) begin
      decision_type exp_d;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_decisions.size() == 0) begin
               $display("%0t: result item with nothing expected, expected none, actual %0h",
                        $time, {rsp_stop_reached, rsp_distance_valid, rsp_sector,
                                rsp_closest_distance, rsp_left_pwm, rsp_right_pwm});
               mismatches++;
            end else begin
               exp_d = pending_decisions.pop_front();
               check_field("stop_reached", 32'(exp_d.stop), 32'(rsp_stop_reached));
               check_field("distance_valid", 32'(exp_d.dist_valid), 32'(rsp_distance_valid));
               check_field("sector", 32'(exp_d.sector), 32'(rsp_sector));
               check_field("closest_distance", 32'(exp_d.closest), 32'(rsp_closest_distance));
               check_field("left_pwm", 32'(exp_d.left_pwm), 32'(rsp_left_pwm));
               check_field("right_pwm", 32'(exp_d.right_pwm), 32'(rsp_right_pwm));
            end
            stall_left = recv_quiet ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles where neither channel nor the register port moves
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      // directed rows under the reset settings: 80 stop, 300000 us, band 64, 910 +- 70
      // nothing valid, distances ignored
      add_row(0, 0, 0, 0, 0, 32'd0, 1, 0, 0, SECTOR_NONE, 0, 910, 910);
      add_row(0, 0, 65535, 0, 65535, 32'hFFFF_FFFF, 1, 0, 0, SECTOR_NONE, 0, 910, 910);
      // both at full range, centered, becomes the remembered reading
      add_row(0, 1, 65535, 1, 65535, 32'd0, 1, 0, 1, SECTOR_CENTER, 65535, 910, 910);
      // fast closing predicts a stop, repeated item repeats the answer
      add_row(0, 1, 1000, 0, 0, 32'd1000, 1, 1, 1, SECTOR_LEFT, 1000, 0, 0);
      add_row(0, 1, 1000, 0, 0, 32'd1000, 1, 1, 1, SECTOR_LEFT, 1000, 0, 0);
      // new run drops the memory, left only steers
      add_row(1, 1, 1000, 0, 0, 32'd1000, 1, 0, 1, SECTOR_LEFT, 1000, 840, 980);
      // closer but no time elapsed, no prediction
      add_row(0, 0, 0, 1, 999, 32'd1000, 1, 0, 1, SECTOR_RIGHT, 999, 980, 840);
      // zero distance, and exactly at stop distance with the band edge centered
      add_row(0, 1, 0, 1, 65535, 32'd5000, 1, 1, 1, SECTOR_LEFT, 0, 0, 0);
      add_row(0, 1, 80, 1, 144, 32'd6000, 1, 1, 1, SECTOR_CENTER, 80, 0, 0);
      // prediction exactly on the boundary, then one microsecond past it
      add_row(0, 1, 500, 1, 81, 32'd275401000, 1, 1, 1, SECTOR_RIGHT, 81, 0, 0);
      add_row(0, 1, 500, 1, 81, 32'd275401001, 1, 0, 1, SECTOR_RIGHT, 81, 980, 840);
      // elapsed time across the counter wrap
      add_row(1, 1, 2000, 1, 2000, 32'hFFFF_FF00, 1, 0, 1, SECTOR_CENTER, 2000, 910, 910);
      add_row(0, 1, 1900, 1, 1900, 32'h0000_0100, 1, 1, 1, SECTOR_CENTER, 1900, 0, 0);
      // moving away never predicts
      add_row(0, 1, 3000, 1, 3000, 32'h0000_1000, 1, 0, 1, SECTOR_CENTER, 3000, 910, 910);
      add_row(1, 1, 65535, 0, 0, 32'hFFFF_FFFF, 1, 0, 1, SECTOR_LEFT, 65535, 840, 980);
      add_row(0, 0, 0, 1, 65535, 32'hFFFF_FFFF, 1, 0, 1, SECTOR_RIGHT, 65535, 980, 840);
      // one past the band on each side
      add_row(0, 1, 1000, 1, 1065, 32'd0, 0, 0, 0, SECTOR_NONE, 0, 0, 0);
      add_row(1, 1, 1065, 1, 1000, 32'd50, 0, 0, 0, SECTOR_NONE, 0, 0, 0);
      // new run on an empty reading still clears the memory
      add_row(1, 0, 123, 0, 456, 32'd7, 1, 0, 0, SECTOR_NONE, 0, 910, 910);
      add_row(0, 1, 500, 1, 500, 32'd60, 1, 0, 1, SECTOR_CENTER, 500, 910, 910);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_reading(directed_rows[i].rd, directed_rows[i].typed, directed_rows[i].want);
      drain_results();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: apply_settings(32'd80, 32'd300000, 32'd64, 32'd910, 32'd70);
            1: apply_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
            2: apply_settings(32'hFFFF, 32'hFF_FFFF, 32'hFFFF, 32'd1023, 32'd1023);
            3: apply_settings(32'd0, 32'hFF_FFFF, 32'd0, 32'd1023, 32'd1023);
            4: apply_settings(32'd40, 32'd1000000, 32'd200, 32'd0, 32'd1023);
            5: apply_settings($urandom, $urandom, $urandom, $urandom, $urandom);
            default: begin
               // sensible ranges, garbage above each register's width
               apply_settings($urandom_range(0, 3000) | ($urandom << 16),
                              $urandom_range(0, 3000000) | ($urandom << 24),
                              $urandom_range(0, 800) | ($urandom << 16),
                              $urandom,
                              $urandom_range(0, 400) | ($urandom << PWM_W));
            end
         endcase
         repeat (ITEMS_PER_PHASE) begin
            // now and then hold off until the pipe is empty
            if ($urandom_range(0, 99) == 0) drain_results();
            offer_reading(next_reading(), 1'b0, '0);
         end
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/suas_pkg.sv
src/suas_lane.sv
src/suas_pred.sv
src/stereo_ultrasonic_approach_step.sv
src/suas_checker.sv
tb/tb_top.sv
